### hw/rtl/rgbhue_pkg.sv
// Shared constants and types for the RGB to hue sextant index block.
// No dependencies; the interfaces and the top level import this package.
package rgbhue_pkg;

  localparam int unsigned InWidth   = 16;
  localparam int unsigned CompWidth = 16;
  localparam int unsigned FracBits  = 8;
  localparam int unsigned OutWidth  = 16;

  // Width of one sextant of the hue circle.
  localparam int unsigned HueStep   = 256 / 6;

  // The quotient never exceeds HueStep << FracBits, and HueStep is below 64.
  localparam int unsigned QuotWidth = FracBits + 6;
  localparam int unsigned NumWidth  = CompWidth + QuotWidth;
  localparam int unsigned BaseWidth = FracBits + 8;
  localparam int unsigned SumWidth  = BaseWidth + 1;

  typedef logic [CompWidth-1:0] comp_t;
  typedef logic [1:0]           chan_t;
  typedef logic [2:0]           sext_t;

  localparam chan_t ChanRed   = 2'd0;
  localparam chan_t ChanGreen = 2'd1;
  localparam chan_t ChanBlue  = 2'd2;

  localparam sext_t SextRedMax   = 3'd0;
  localparam sext_t SextGreenFal = 3'd1;
  localparam sext_t SextGreenMax = 3'd2;
  localparam sext_t SextBlueFal  = 3'd3;
  localparam sext_t SextBlueMax  = 3'd4;
  localparam sext_t SextRedFal   = 3'd5;

endpackage

### hw/rtl/rgbhue_if.sv
// Valid/ready channel interfaces for color input and hue output.
// Depends on rgbhue_pkg for the field widths.
interface rgbhue_in_if;
  import rgbhue_pkg::*;

  logic                valid;
  logic                ready;
  logic [InWidth-1:0]  red_level;
  logic [InWidth-1:0]  green_level;
  logic [InWidth-1:0]  blue_level;

  modport source(output valid, output red_level, output green_level, output blue_level,
                 input ready);
  modport sink(input valid, input red_level, input green_level, input blue_level,
               output ready);
endinterface

interface rgbhue_out_if;
  import rgbhue_pkg::*;

  logic                valid;
  logic                ready;
  logic [OutWidth-1:0] hue_index;

  modport source(output valid, output hue_index, input ready);
  modport sink(input valid, input hue_index, output ready);
endinterface

### hw/rtl/rgb_to_hue_sextant_index.sv
// Top level of the RGB to hue sextant index block.
// Depends on rgbhue_pkg and the channel interfaces in rgbhue_if.
//
// The block takes one color transfer per cycle while the output is not stalled
// and returns its hue index from the output register. The first two stages
// remove the smallest component and pick the sextant, the third forms the
// scaled numerator, then one restoring divide stage per quotient bit follows,
// and a last stage adds the sextant base into the output register.
// The whole pipeline holds when the output is stalled; gray input gives 0.
module rgb_to_hue_sextant_index (
  input  logic clk_i,
  input  logic rst_ni,
  rgbhue_in_if.sink    rgb_i,
  rgbhue_out_if.source hue_o
);
  import rgbhue_pkg::*;

  logic adv;

  // Stage 1: smallest component removed.
  logic  s1_v_q;
  comp_t s1_c_q [3];
  chan_t s1_lo_q;

  // Stage 2: sextant, divisor and middle term.
  logic  s2_v_q;
  comp_t s2_d_q;
  comp_t s2_m_q;
  sext_t s2_sext_q;
  logic  s2_gray_q;

  // Divide stages; index 0 is loaded with the scaled numerator.
  logic                 dv_v_q    [QuotWidth+1];
  comp_t                dv_r_q    [QuotWidth+1];
  logic [QuotWidth-1:0] dv_n_q    [QuotWidth+1];
  logic [QuotWidth-1:0] dv_q_q    [QuotWidth+1];
  comp_t                dv_d_q    [QuotWidth+1];
  sext_t                dv_sext_q [QuotWidth+1];
  logic                 dv_gray_q [QuotWidth+1];

  comp_t                dv_r_d [QuotWidth];
  logic [QuotWidth-1:0] dv_q_d [QuotWidth];

  logic                out_v_q;
  logic [OutWidth-1:0] out_hue_q;

  comp_t              c_in [3];
  chan_t              lo_d;
  comp_t              c_min;
  chan_t              hi_d;
  comp_t              d_d;
  comp_t              m_d;
  sext_t              sext_d;
  logic [NumWidth-1:0] num_d;
  logic [BaseWidth-1:0] base_d;
  logic [SumWidth-1:0] sum_d;

  assign adv = !out_v_q || hue_o.ready;
  assign rgb_i.ready = adv;
  assign hue_o.valid = out_v_q;
  assign hue_o.hue_index = out_hue_q;

  // Smallest component, ties to the earlier one.
  always_comb begin
    c_in[0] = CompWidth'(rgb_i.red_level);
    c_in[1] = CompWidth'(rgb_i.green_level);
    c_in[2] = CompWidth'(rgb_i.blue_level);
    lo_d  = ChanRed;
    c_min = c_in[0];
    if (c_in[1] < c_min) begin
      lo_d  = ChanGreen;
      c_min = c_in[1];
    end
    if (c_in[2] < c_min) begin
      lo_d  = ChanBlue;
      c_min = c_in[2];
    end
  end

  // Largest remainder and sextant selection.
  always_comb begin
    hi_d = ChanRed;
    d_d  = s1_c_q[0];
    if (s1_c_q[1] > d_d) begin
      hi_d = ChanGreen;
      d_d  = s1_c_q[1];
    end
    if (s1_c_q[2] > d_d) begin
      hi_d = ChanBlue;
      d_d  = s1_c_q[2];
    end
    sext_d = SextRedFal;
    m_d    = d_d - s1_c_q[2];
    case (hi_d)
      ChanRed: begin
        if (s1_lo_q == ChanBlue) begin
          sext_d = SextRedMax;
          m_d    = s1_c_q[1];
        end
      end
      ChanGreen: begin
        if (s1_lo_q == ChanBlue) begin
          sext_d = SextGreenFal;
          m_d    = d_d - s1_c_q[0];
        end else begin
          sext_d = SextGreenMax;
          m_d    = s1_c_q[2];
        end
      end
      ChanBlue: begin
        if (s1_lo_q == ChanRed) begin
          sext_d = SextBlueFal;
          m_d    = d_d - s1_c_q[1];
        end else begin
          sext_d = SextBlueMax;
          m_d    = s1_c_q[0];
        end
      end
      default: begin
        sext_d = SextRedFal;
        m_d    = d_d - s1_c_q[2];
      end
    endcase
  end

  assign num_d = (NumWidth'(s2_m_q) * NumWidth'(HueStep)) << FracBits;

  // One restoring divide step per stage.
  always_comb begin
    for (int k = 0; k < QuotWidth; k++) begin
      logic [CompWidth:0] trial;
      logic               ge;
      trial     = {dv_r_q[k], dv_n_q[k][QuotWidth-1]};
      ge        = trial >= {1'b0, dv_d_q[k]};
      dv_r_d[k] = ge ? CompWidth'(trial - {1'b0, dv_d_q[k]}) : trial[CompWidth-1:0];
      dv_q_d[k] = {dv_q_q[k][QuotWidth-2:0], ge};
    end
  end

  assign base_d = (BaseWidth'(dv_sext_q[QuotWidth]) * BaseWidth'(HueStep)) << FracBits;
  assign sum_d  = SumWidth'(base_d) + SumWidth'(dv_q_q[QuotWidth]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      for (int k = 0; k <= QuotWidth; k++) begin
        dv_v_q[k] <= 1'b0;
      end
    end else if (adv) begin
      s1_v_q  <= rgb_i.valid;
      s2_v_q  <= s1_v_q;
      dv_v_q[0] <= s2_v_q;
      for (int k = 0; k < QuotWidth; k++) begin
        dv_v_q[k+1] <= dv_v_q[k];
      end
      out_v_q <= dv_v_q[QuotWidth];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        s1_c_q[k] <= c_in[k] - c_min;
      end
      s1_lo_q <= lo_d;

      s2_d_q    <= d_d;
      s2_m_q    <= m_d;
      s2_sext_q <= sext_d;
      s2_gray_q <= (d_d == '0);

      dv_r_q[0]    <= num_d[NumWidth-1:QuotWidth];
      dv_n_q[0]    <= num_d[QuotWidth-1:0];
      dv_q_q[0]    <= '0;
      dv_d_q[0]    <= s2_d_q;
      dv_sext_q[0] <= s2_sext_q;
      dv_gray_q[0] <= s2_gray_q;
      for (int k = 0; k < QuotWidth; k++) begin
        dv_r_q[k+1]    <= dv_r_d[k];
        dv_n_q[k+1]    <= dv_n_q[k] << 1;
        dv_q_q[k+1]    <= dv_q_d[k];
        dv_d_q[k+1]    <= dv_d_q[k];
        dv_sext_q[k+1] <= dv_sext_q[k];
        dv_gray_q[k+1] <= dv_gray_q[k];
      end

      out_hue_q <= dv_gray_q[QuotWidth] ? '0 : OutWidth'(sum_d);
    end
  end

endmodule

### bench/rgb_to_hue_sextant_index_tb.sv
// Self-checking testbench for rgb_to_hue_sextant_index: directed corner rows, then random colors.
// Hues are checked against known row hues or an in-bench predictor, with idle and stall phases on both sides.
// Depends on rgbhue_pkg and the rgbhue_in_if / rgbhue_out_if channel interfaces.
`timescale 1ns / 100ps

module rgb_to_hue_sextant_index_tb;
  import rgbhue_pkg::*;

  localparam int QuietLimit  = 2000;
  localparam int HoldCycles  = 300;
  localparam int DrainCycles = QuotWidth + 24;
  localparam int DirRows     = 24;

  typedef struct packed {
    logic [InWidth-1:0] red;
    logic [InWidth-1:0] green;
    logic [InWidth-1:0] blue;
  } color_t;

  typedef struct packed {
    color_t              color;
    logic                known;
    logic [OutWidth-1:0] hue;
  } color_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  rgbhue_in_if  rgb_if();
  rgbhue_out_if hue_if();

  rgb_to_hue_sextant_index dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rgb_i  (rgb_if),
    .hue_o  (hue_if)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  logic [OutWidth-1:0] expected_hues[$];
  int idle_pct      = 0;
  int stall_pct     = 0;
  bit hold_pending  = 1'b0;
  int colors_sent   = 0;
  int hues_seen     = 0;
  int error_count   = 0;
  int quiet_cycles  = 0;

  // Hue rows: color, whether the hue is written in, and that hue.
  color_row_t directed_rows [DirRows] = '{
    '{'{16'd0,     16'd0,     16'd0    }, 1'b1, 16'd0    },
    '{'{16'd65535, 16'd65535, 16'd65535}, 1'b1, 16'd0    },
    '{'{16'd65535, 16'd0,     16'd0    }, 1'b1, 16'd64512},
    '{'{16'd0,     16'd65535, 16'd0    }, 1'b1, 16'd21504},
    '{'{16'd0,     16'd0,     16'd65535}, 1'b1, 16'd43008},
    '{'{16'd65535, 16'd65535, 16'd0    }, 1'b1, 16'd10752},
    '{'{16'd0,     16'd65535, 16'd65535}, 1'b1, 16'd32256},
    '{'{16'd65535, 16'd0,     16'd65535}, 1'b1, 16'd53760},
    '{'{16'd1,     16'd0,     16'd0    }, 1'b1, 16'd64512},
    '{'{16'd1,     16'd1,     16'd0    }, 1'b1, 16'd10752},
    '{'{16'd0,     16'd1,     16'd1    }, 1'b1, 16'd32256},
    '{'{16'd1,     16'd0,     16'd1    }, 1'b1, 16'd53760},
    '{'{16'd60000, 16'd20000, 16'd1000 }, 1'b0, 16'd0    },
    '{'{16'd30000, 16'd50000, 16'd100  }, 1'b0, 16'd0    },
    '{'{16'd5,     16'd40000, 16'd22222}, 1'b0, 16'd0    },
    '{'{16'd7,     16'd12345, 16'd65535}, 1'b0, 16'd0    },
    '{'{16'd40000, 16'd3,     16'd65534}, 1'b0, 16'd0    },
    '{'{16'd65535, 16'd2,     16'd30000}, 1'b0, 16'd0    },
    '{'{16'd65534, 16'd65535, 16'd1    }, 1'b0, 16'd0    },
    '{'{16'd32768, 16'd32767, 16'd32767}, 1'b1, 16'd64512},
    '{'{16'd12345, 16'd12345, 16'd12345}, 1'b1, 16'd0    },
    '{'{16'd43690, 16'd21845, 16'd0    }, 1'b0, 16'd0    },
    '{'{16'hAAAA,  16'h5555,  16'hFFFF }, 1'b0, 16'd0    },
    '{'{16'h5555,  16'hAAAA,  16'hFFFF }, 1'b0, 16'd0    }
  };

  function automatic logic [OutWidth-1:0] predict_hue(color_t c);
    logic [63:0] lvl [3];
    logic [63:0] floor_lvl;
    logic [63:0] span;
    logic [63:0] mid;
    logic [63:0] hue;
    chan_t       lo;
    chan_t       hi;
    sext_t       sext;
    lvl[0] = 64'(c.red)   & ((64'd1 << CompWidth) - 64'd1);
    lvl[1] = 64'(c.green) & ((64'd1 << CompWidth) - 64'd1);
    lvl[2] = 64'(c.blue)  & ((64'd1 << CompWidth) - 64'd1);
    lo = ChanRed;
    for (int k = 1; k < 3; k++) begin
      if (lvl[k] < lvl[lo]) lo = chan_t'(k);
    end
    floor_lvl = lvl[lo];
    for (int k = 0; k < 3; k++) lvl[k] = lvl[k] - floor_lvl;
    hi = ChanRed;
    for (int k = 1; k < 3; k++) begin
      if (lvl[k] > lvl[hi]) hi = chan_t'(k);
    end
    span = lvl[hi];
    if (span == 64'd0) return '0;
    if (hi == ChanRed && lo == ChanBlue) begin
      sext = SextRedMax;
      mid  = lvl[ChanGreen];
    end else if (hi == ChanGreen && lo == ChanBlue) begin
      sext = SextGreenFal;
      mid  = span - lvl[ChanRed];
    end else if (hi == ChanGreen && lo == ChanRed) begin
      sext = SextGreenMax;
      mid  = lvl[ChanBlue];
    end else if (hi == ChanBlue && lo == ChanRed) begin
      sext = SextBlueFal;
      mid  = span - lvl[ChanGreen];
    end else if (hi == ChanBlue && lo == ChanGreen) begin
      sext = SextBlueMax;
      mid  = lvl[ChanRed];
    end else begin
      sext = SextRedFal;
      mid  = span - lvl[ChanBlue];
    end
    hue = (64'(sext) * 64'(HueStep)) << FracBits;
    hue = hue + (((64'(HueStep) * mid) << FracBits) / span);
    return hue[OutWidth-1:0];
  endfunction

  function automatic color_t random_color();
    color_t c;
    int     base;
    c.red   = InWidth'($urandom);
    c.green = InWidth'($urandom);
    c.blue  = InWidth'($urandom);
    case ($urandom_range(7))
      2: begin
        c.green = c.red;
        c.blue  = c.red;
      end
      3: begin
        case ($urandom_range(2))
          0: c.green = c.red;
          1: c.blue = c.green;
          default: c.blue = c.red;
        endcase
      end
      4: begin
        case ($urandom_range(2))
          0: c.red = '0;
          1: c.red = '1;
          default: ;
        endcase
        case ($urandom_range(2))
          0: c.green = '0;
          1: c.green = '1;
          default: ;
        endcase
        case ($urandom_range(2))
          0: c.blue = '0;
          1: c.blue = '1;
          default: ;
        endcase
      end
      5: begin
        c.red   = InWidth'($urandom_range(3));
        c.green = InWidth'($urandom_range(3));
        c.blue  = InWidth'($urandom_range(3));
      end
      6: begin
        base    = $urandom_range(65532);
        c.red   = InWidth'(base + $urandom_range(3));
        c.green = InWidth'(base + $urandom_range(3));
        c.blue  = InWidth'(base + $urandom_range(3));
      end
      7: begin
        case ($urandom_range(2))
          0: c.red = '0;
          1: c.green = '0;
          default: c.blue = '0;
        endcase
      end
      default: ;
    endcase
    return c;
  endfunction

  task automatic send_color(input color_t c, input logic known, input logic [OutWidth-1:0] hue);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      rgb_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    rgb_if.valid       <= 1'b1;
    rgb_if.red_level   <= c.red;
    rgb_if.green_level <= c.green;
    rgb_if.blue_level  <= c.blue;
    do @(posedge clk_i); while (!rgb_if.ready);
    expected_hues.push_back(known ? hue : predict_hue(c));
    colors_sent++;
    @(negedge clk_i);
  endtask

  task automatic run_random(input int count, input int idle, input int stall);
    idle_pct  = idle;
    stall_pct = stall;
    repeat (count) send_color(random_color(), 1'b0, '0);
  endtask

  initial begin
    hue_if.ready = 1'b0;
    forever begin
      int hold_left;
      @(negedge clk_i);
      if (hold_pending) begin
        hold_pending = 1'b0;
        hold_left    = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        hue_if.ready <= 1'b0;
      end else begin
        hue_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    logic [OutWidth-1:0] want;
    if (rst_ni && hue_if.valid && hue_if.ready) begin
      hues_seen++;
      if (expected_hues.size() == 0) begin
        $error("hue_index transfer with no color pending: actual %0d", hue_if.hue_index);
        error_count++;
      end else begin
        want = expected_hues.pop_front();
        if (hue_if.hue_index !== want) begin
          $error("hue_index mismatch: expected %0d, actual %0d", want, hue_if.hue_index);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((rgb_if.valid && rgb_if.ready) || (hue_if.valid && hue_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= QuietLimit) begin
        $display("Timeout after %0d cycles without a transfer", QuietLimit);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_ni             = 1'b0;
    rgb_if.valid       = 1'b0;
    rgb_if.red_level   = '0;
    rgb_if.green_level = '0;
    rgb_if.blue_level  = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      send_color(directed_rows[i].color, directed_rows[i].known, directed_rows[i].hue);
    end

    run_random(400, 0, 0);
    idle_pct     = 0;
    stall_pct    = 0;
    hold_pending = 1'b1;
    repeat (150) send_color(random_color(), 1'b0, '0);
    run_random(400, 75, 0);
    run_random(400, 0, 75);
    run_random(400, 19, 19);

    rgb_if.valid <= 1'b0;
    while (expected_hues.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d color transfers (%0d directed rows) and checked %0d hue results,",
             colors_sent, DirRows, hues_seen);
    $display("with sender gaps, receiver stalls and one long output hold-off.");
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/rgbhue_pkg.sv
hw/rtl/rgbhue_if.sv
hw/rtl/rgb_to_hue_sextant_index.sv
bench/rgb_to_hue_sextant_index_tb.sv
